>>> rtl/baro_sensor_compensation_top_assert.svh
// Assertion helpers for the barometer compensation block.
// Each macro samples on clk and is quiet while rst_n is low.
`ifndef BARO_SENSOR_COMPENSATION_TOP_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_TOP_ASSERT_SVH

// Same-cycle implication.
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    // Calibration register indexes
    typedef enum logic [2:0] {
        CFG_SENS        = 3'd0,
        CFG_OFFSET      = 3'd1,
        CFG_SENS_TEMP   = 3'd2,
        CFG_OFFSET_TEMP = 3'd3,
        CFG_REF_TEMP    = 3'd4,
        CFG_TEMP_SLOPE  = 3'd5
    } cfg_idx_t;

    localparam logic signed [18:0] TEMP_REF     = 19'sd2000;
    // temp + 1500 expressed from temp - 2000
    localparam logic signed [18:0] TEMP_LOW_OFS = 19'sd3500;
    localparam logic [19:0]        P_MAX        = 20'hFFFFF;
    localparam logic [15:0]        TEMP_MIN     = 16'h8000;
    localparam logic [15:0]        TEMP_MAX     = 16'h7FFF;

    typedef struct packed {
        logic [15:0] sens;
        logic [15:0] offset;
        logic [15:0] sens_temp;
        logic [15:0] offset_temp;
        logic [15:0] ref_temp;
        logic [15:0] temp_slope;
    } cal_t;

    // First-order results
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [17:0] a;      // temp - 2000
        logic signed [18:0] temp1;
        logic [17:0]        t2;
        logic signed [35:0] off;
        logic signed [34:0] sens;
    } front_t;

    // Second-order corrected values
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [19:0] temp;
        logic signed [41:0] off;
        logic signed [39:0] sens;
    } corr_t;

endpackage

`default_nettype wire

>>> rtl/bsc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

`default_nettype wire

>>> rtl/bsc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic [19:0]        pressure_pa;
    logic signed [15:0] temperature_centi;
    logic               clipped;

    modport source (
        output valid, output pressure_pa, output temperature_centi, output clipped,
        input ready
    );
    modport sink (
        input valid, input pressure_pa, input temperature_centi, input clipped,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/bsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [23:0]     raw_pressure,
    input  wire logic [23:0]     raw_temperature,
    input  wire bsc_pkg::cal_t   cal,
    output logic                 out_valid,
    output bsc_pkg::front_t      out_data
);

    logic [2:0]          valid_reg;
    logic [23:0]         d1_s1_reg;
    logic [23:0]         d1_s2_reg;
    logic signed [24:0]  dt_next;
    logic signed [24:0]  dt_reg;
    logic signed [41:0]  mt_next;
    logic signed [41:0]  mo_next;
    logic signed [41:0]  ms_next;
    logic signed [41:0]  mt_reg;
    logic signed [41:0]  mo_reg;
    logic signed [41:0]  ms_reg;
    logic signed [49:0]  dd_next;
    logic [48:0]         dd_reg;
    bsc_pkg::front_t     s3_next;
    bsc_pkg::front_t     s3_reg;

    assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ref_temp, 8'h00});

    assign mt_next = dt_reg * $signed({1'b0, cal.temp_slope});
    assign mo_next = dt_reg * $signed({1'b0, cal.offset_temp});
    assign ms_next = dt_reg * $signed({1'b0, cal.sens_temp});
    assign dd_next = dt_reg * dt_reg;

    // Floor shifts are part-selects of the two's complement products
    always_comb
    begin
        s3_next.d1    = d1_s2_reg;
        s3_next.a     = mt_reg[40:23];
        s3_next.temp1 = bsc_pkg::TEMP_REF + $signed({mt_reg[40], mt_reg[40:23]});
        s3_next.t2    = dd_reg[48:31];
        s3_next.off   = $signed({3'b000, cal.offset, 17'h00000})
                      + $signed({mo_reg[40], mo_reg[40:6]});
        s3_next.sens  = $signed({3'b000, cal.sens, 16'h0000})
                      + $signed({ms_reg[40], ms_reg[40:7]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_s1_reg <= raw_pressure;
            dt_reg    <= dt_next;
            d1_s2_reg <= d1_s1_reg;
            mt_reg    <= mt_next;
            mo_reg    <= mo_next;
            ms_reg    <= ms_next;
            dd_reg    <= dd_next[48:0];
            s3_reg    <= s3_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = s3_reg;

endmodule

`default_nettype wire

>>> rtl/bsc_corr.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_corr (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire bsc_pkg::front_t in_data,
    output logic                 out_valid,
    output bsc_pkg::corr_t       out_data
);

    logic [2:0]          valid_reg;

    // Squares
    logic signed [35:0]  a2_next;
    logic signed [18:0]  b_val;
    logic signed [37:0]  b2_next;
    logic [34:0]         a2_reg;
    logic [35:0]         b2_reg;
    logic                low_reg;
    logic                bneg_reg;
    logic [23:0]         d1_s4_reg;
    logic signed [18:0]  temp1_s4_reg;
    logic [17:0]         t2_s4_reg;
    logic signed [35:0]  off_s4_reg;
    logic signed [34:0]  sens_s4_reg;

    // Correction terms
    logic [40:0]         a2x61;
    logic [39:0]         b2x15;
    logic [36:0]         off2a_next;
    logic [37:0]         off2b_next;
    logic [35:0]         sens2a_next;
    logic [37:0]         sens2b_next;
    logic signed [19:0]  temp_next;
    logic [36:0]         off2a_reg;
    logic [37:0]         off2b_reg;
    logic [35:0]         sens2a_reg;
    logic [37:0]         sens2b_reg;
    logic signed [19:0]  temp_s5_reg;
    logic [23:0]         d1_s5_reg;
    logic signed [35:0]  off_s5_reg;
    logic signed [34:0]  sens_s5_reg;

    bsc_pkg::corr_t      s6_next;
    bsc_pkg::corr_t      s6_reg;

    assign a2_next = in_data.a * in_data.a;
    assign b_val   = $signed({in_data.a[17], in_data.a}) + bsc_pkg::TEMP_LOW_OFS;
    assign b2_next = b_val * b_val;

    assign a2x61 = {a2_reg, 6'b0} - {4'b0, a2_reg, 2'b0} + {6'b0, a2_reg};
    assign b2x15 = {b2_reg, 4'b0} - {4'b0, b2_reg};

    // Below -15.00 C the square of temp + 1500 stays under 2^34
    assign off2a_next  = low_reg ? a2x61[40:4] : '0;
    assign off2b_next  = (low_reg && bneg_reg) ? b2x15[37:0] : '0;
    assign sens2a_next = low_reg ? {a2_reg, 1'b0} : '0;
    assign sens2b_next = (low_reg && bneg_reg) ? {b2_reg[34:0], 3'b000} : '0;
    assign temp_next   = $signed({temp1_s4_reg[18], temp1_s4_reg})
                       - $signed(low_reg ? {2'b00, t2_s4_reg} : 20'd0);

    always_comb
    begin
        s6_next.d1   = d1_s5_reg;
        s6_next.temp = temp_s5_reg;
        s6_next.off  = $signed({{6{off_s5_reg[35]}}, off_s5_reg})
                     - $signed({5'b0, off2a_reg}) - $signed({4'b0, off2b_reg});
        s6_next.sens = $signed({{5{sens_s5_reg[34]}}, sens_s5_reg})
                     - $signed({4'b0, sens2a_reg}) - $signed({2'b0, sens2b_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg       <= a2_next[34:0];
            b2_reg       <= b2_next[35:0];
            low_reg      <= in_data.a[17];
            bneg_reg     <= b_val[18];
            d1_s4_reg    <= in_data.d1;
            temp1_s4_reg <= in_data.temp1;
            t2_s4_reg    <= in_data.t2;
            off_s4_reg   <= in_data.off;
            sens_s4_reg  <= in_data.sens;

            off2a_reg    <= off2a_next;
            off2b_reg    <= off2b_next;
            sens2a_reg   <= sens2a_next;
            sens2b_reg   <= sens2b_next;
            temp_s5_reg  <= temp_next;
            d1_s5_reg    <= d1_s4_reg;
            off_s5_reg   <= off_s4_reg;
            sens_s5_reg  <= sens_s4_reg;

            s6_reg       <= s6_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = s6_reg;

endmodule

`default_nettype wire

>>> rtl/bsc_press.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_press (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire bsc_pkg::corr_t in_data,
    output logic                out_valid,
    output logic [19:0]         pressure_pa,
    output logic signed [15:0]  temperature_centi,
    output logic                clipped
);

    logic [2:0]          valid_reg;

    logic [44:0]         pp_lo_next;
    logic signed [43:0]  pp_hi_next;
    logic                tclip_next;
    logic [15:0]         tsat_next;
    logic [44:0]         pp_lo_reg;
    logic signed [43:0]  pp_hi_reg;
    logic                tclip_s7_reg;
    logic [15:0]         tsat_s7_reg;
    logic signed [41:0]  off_s7_reg;

    logic signed [43:0]  pmid_next;
    logic signed [43:0]  pmid_reg;
    logic                tclip_s8_reg;
    logic [15:0]         tsat_s8_reg;
    logic signed [41:0]  off_s8_reg;

    logic signed [44:0]  diff;
    logic [29:0]         p_full;
    logic                pclip_next;
    logic [19:0]         psat_next;
    logic [19:0]         pressure_reg;
    logic [15:0]         temp_reg;
    logic                clipped_reg;

    // Split sens at bit 21: the low half is non-negative, so its floor
    // shift folds into the high product without loss
    assign pp_lo_next = in_data.d1 * in_data.sens[20:0];
    assign pp_hi_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:21]);

    assign tclip_next = !((&in_data.temp[19:15]) || (~|in_data.temp[19:15]));
    assign tsat_next  = tclip_next ? (in_data.temp[19] ? bsc_pkg::TEMP_MIN : bsc_pkg::TEMP_MAX)
                                   : in_data.temp[15:0];

    assign pmid_next = pp_hi_reg + $signed({20'b0, pp_lo_reg[44:21]});

    assign diff   = $signed({pmid_reg[43], pmid_reg}) - $signed({{3{off_s8_reg[41]}}, off_s8_reg});
    assign p_full = diff[44:15];

    always_comb
    begin
        if (p_full[29])
        begin
            psat_next  = '0;
            pclip_next = 1'b1;
        end
        else if (|p_full[28:20])
        begin
            psat_next  = bsc_pkg::P_MAX;
            pclip_next = 1'b1;
        end
        else
        begin
            psat_next  = p_full[19:0];
            pclip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_lo_reg    <= pp_lo_next;
            pp_hi_reg    <= pp_hi_next;
            tclip_s7_reg <= tclip_next;
            tsat_s7_reg  <= tsat_next;
            off_s7_reg   <= in_data.off;

            pmid_reg     <= pmid_next;
            tclip_s8_reg <= tclip_s7_reg;
            tsat_s8_reg  <= tsat_s7_reg;
            off_s8_reg   <= off_s7_reg;

            pressure_reg <= psat_next;
            temp_reg     <= tsat_s8_reg;
            clipped_reg  <= pclip_next | tclip_s8_reg;
        end
    end

    assign out_valid         = valid_reg[2];
    assign pressure_pa       = pressure_reg;
    assign temperature_centi = $signed(temp_reg);
    assign clipped           = clipped_reg;

endmodule

`default_nettype wire

>>> rtl/baro_sensor_compensation_top.sv
// Barometer compensation: turns one raw pressure/temperature conversion pair
// into pressure in Pa and temperature in 0.01 C, with second-order correction.
// - raw_ch (sink): a request carries raw_pressure and raw_temperature, 24 bits.
// - comp_ch (source): pressure_pa (20 bits), temperature_centi (16 bits, signed)
//   and clipped, set when either value hit the end of its range.
// - cfg_we/cfg_index/cfg_data: write one of the six 16-bit calibration words;
//   write them only while no request is in flight.
// Throughput: one request per cycle, sustained while comp_ch takes every result.
// Pipeline: nine register ranks between raw_ch and comp_ch. The ranks:
// difference, first multiplier rank, first-order sums, squares, correction
// terms, corrected sums, pressure partial products, partial-product merge,
// offset subtract with saturation.
// Reset: the pipeline empties and every calibration word reads zero.
// Stall: while comp_ch holds a result that is not taken, the whole pipeline
// holds and raw_ch.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module baro_sensor_compensation_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bsc_in_if.sink     raw_ch,
    bsc_out_if.source  comp_ch,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    bsc_pkg::cal_t   cal_reg;
    logic            en;
    logic            front_valid;
    bsc_pkg::front_t front_data;
    logic            corr_valid;
    bsc_pkg::corr_t  corr_data;

    // Advance every stage unless the output holds a result the sink refuses
    assign en           = !comp_ch.valid || comp_ch.ready;
    assign raw_ch.ready = en;

    // Calibration words; writes to unused indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsc_pkg::CFG_SENS:        cal_reg.sens        <= cfg_data;
                bsc_pkg::CFG_OFFSET:      cal_reg.offset      <= cfg_data;
                bsc_pkg::CFG_SENS_TEMP:   cal_reg.sens_temp   <= cfg_data;
                bsc_pkg::CFG_OFFSET_TEMP: cal_reg.offset_temp <= cfg_data;
                bsc_pkg::CFG_REF_TEMP:    cal_reg.ref_temp    <= cfg_data;
                bsc_pkg::CFG_TEMP_SLOPE:  cal_reg.temp_slope  <= cfg_data;
                default:                  cal_reg             <= cal_reg;
            endcase
        end
    end

    // First order: dT, TEMP, OFF, SENS
    bsc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (raw_ch.valid),
        .raw_pressure    (raw_ch.raw_pressure),
        .raw_temperature (raw_ch.raw_temperature),
        .cal             (cal_reg),
        .out_valid       (front_valid),
        .out_data        (front_data)
    );

    // Second order: T2, OFF2, SENS2 below 20.00 C and -15.00 C
    bsc_corr u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (corr_valid),
        .out_data  (corr_data)
    );

    // Pressure product, final shift and saturation; holds the output register
    bsc_press u_press (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (corr_valid),
        .in_data           (corr_data),
        .out_valid         (comp_ch.valid),
        .pressure_pa       (comp_ch.pressure_pa),
        .temperature_centi (comp_ch.temperature_centi),
        .clipped           (comp_ch.clipped)
    );

endmodule

`default_nettype wire

>>> rtl/bsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "baro_sensor_compensation_top_assert.svh"

module bsc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [19:0]        pressure_pa,
    input wire logic signed [15:0] temperature_centi,
    input wire logic               clipped
);

    // A refused result must hold unchanged
    `BSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pressure_pa) && $stable(temperature_centi) && $stable(clipped), "refused result changed")

    // Input side stalls exactly when the output register is blocked
    `BSC_ASSERT_NOW(a_ready_rule, in_valid || !in_valid, in_ready == !(out_valid && !out_ready), "input ready does not follow output stall")

    // A clipped result sits at an end of its range
    `BSC_ASSERT_NOW(a_clip_bound, out_valid && clipped, pressure_pa == 20'd0 || pressure_pa == bsc_pkg::P_MAX || temperature_centi == $signed(bsc_pkg::TEMP_MIN) || temperature_centi == $signed(bsc_pkg::TEMP_MAX), "clipped flag without a saturated value")

endmodule

bind baro_sensor_compensation_top bsc_checker u_bsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (raw_ch.valid),
    .in_ready          (raw_ch.ready),
    .out_valid         (comp_ch.valid),
    .out_ready         (comp_ch.ready),
    .pressure_pa       (comp_ch.pressure_pa),
    .temperature_centi (comp_ch.temperature_centi),
    .clipped           (comp_ch.clipped)
);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    // Register ranks of the block between raw_ch and comp_ch.
    localparam int PIPE_DEPTH = 9;
    localparam int IDLE_PCT = 32;
    localparam int HOLD_LEN = 120;
    localparam int RAND_PHASES = 6;
    localparam int RAND_PER_PHASE = 116;
    localparam int CYCLE_LIMIT = 100000;

    // Register indexes past the last calibration word; writes there must be ignored.
    localparam logic [2:0] IDX_SPARE_LO = 3'd6;
    localparam logic [2:0] IDX_SPARE_HI = 3'd7;

    // Compensation constants, in 0.01 C and Pa.
    localparam longint TEMP_PIVOT = 2000;
    localparam longint TEMP_COLD = -1500;
    localparam longint PRESS_CEIL = 1048575;
    localparam longint CENTI_FLOOR = -32768;
    localparam longint CENTI_CEIL = 32767;

    typedef struct packed {
        logic [23:0] d1;
        logic [23:0] d2;
    } conversion_t;

    typedef struct packed {
        logic [19:0]        pressure;
        logic signed [15:0] centi;
        logic               clipped;
    } reading_t;

    typedef enum {CAL_NEAR_TYPICAL, CAL_ANY} cal_style_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    bsc_in_if  raw_if ();
    bsc_out_if comp_if ();

    baro_sensor_compensation_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_ch    (raw_if),
        .comp_ch   (comp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the calibration words, updated as each write is issued.
    bsc_pkg::cal_t cal_words;

    conversion_t raw_backlog[$];       // conversions waiting to be offered
    reading_t    pending_readings[$];  // predicted readings, oldest first

    int items_queued;
    int items_taken;
    int readings_seen;
    int clip_count;
    int cold_count;
    int cal_sets;
    int error_count;
    int cycle_count;

    // Stimulus controls: steady sides never idle; each hold_asked bump
    // starts one long hold-off in which the sink refuses results.
    bit sender_steady;
    bit sink_steady;
    int hold_asked;
    int hold_given;
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic flag_mismatch(input string what);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Predict one reading from a raw conversion pair and the current calibration.
    // All shifts are on signed 64-bit values, so >>> floors toward minus infinity.
    function automatic reading_t compensate(input logic [23:0] d1_raw,
                                            input logic [23:0] d2_raw,
                                            output bit cold);
        longint d1, dt, temp, off, sens, t2, off2, sens2, a, b, p;
        reading_t r;
        d1 = d1_raw;
        dt = longint'(d2_raw) - longint'(cal_words.ref_temp) * 256;
        temp = TEMP_PIVOT + ((dt * longint'(cal_words.temp_slope)) >>> 23);
        off = longint'(cal_words.offset) * 131072
            + ((longint'(cal_words.offset_temp) * dt) >>> 6);
        sens = longint'(cal_words.sens) * 65536
             + ((longint'(cal_words.sens_temp) * dt) >>> 7);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        cold = (temp < TEMP_PIVOT);
        if (cold)
        begin
            a = temp - TEMP_PIVOT;
            t2 = (dt * dt) >>> 31;
            off2 = (61 * a * a) >>> 4;
            sens2 = 2 * a * a;
            // Extra term for the very cold range.
            if (temp < TEMP_COLD)
            begin
                b = temp - TEMP_COLD;
                off2 += 15 * b * b;
                sens2 += 8 * b * b;
            end
        end
        temp -= t2;
        off -= off2;
        sens -= sens2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;

        r.clipped = 1'b0;
        if (p < 0)
        begin
            r.pressure = '0;
            r.clipped = 1'b1;
        end
        else if (p > PRESS_CEIL)
        begin
            r.pressure = '1;
            r.clipped = 1'b1;
        end
        else
            r.pressure = p[19:0];
        if (temp < CENTI_FLOOR)
        begin
            r.centi = 16'sh8000;
            r.clipped = 1'b1;
        end
        else if (temp > CENTI_CEIL)
        begin
            r.centi = 16'sh7FFF;
            r.clipped = 1'b1;
        end
        else
            r.centi = temp[15:0];
        return r;
    endfunction

    // Draw one conversion pair. Most land near the reference temperature so
    // readings fall across both sides of the correction thresholds; the rest
    // is full-range noise that exercises every input bit.
    function automatic conversion_t draw_conversion();
        conversion_t c;
        longint d2_near;
        int roll;
        roll = $urandom_range(0, 99);
        d2_near = longint'(cal_words.ref_temp) * 256
                + longint'($urandom_range(0, 1 << 23)) - (1 << 22);
        if (d2_near < 0)
            d2_near = 0;
        if (d2_near > 24'hFFFFFF)
            d2_near = 24'hFFFFFF;
        if (roll < 60)
        begin
            c.d1 = 24'($urandom_range(3000000, 10000000));
            c.d2 = d2_near[23:0];
        end
        else if (roll < 80)
        begin
            c.d1 = 24'($urandom());
            c.d2 = d2_near[23:0];
        end
        else
        begin
            c.d1 = 24'($urandom());
            c.d2 = 24'($urandom());
        end
        return c;
    endfunction

    function automatic void queue_conversion(input logic [23:0] d1, input logic [23:0] d2);
        conversion_t c;
        c.d1 = d1;
        c.d2 = d2;
        raw_backlog.push_back(c);
        items_queued++;
    endfunction

    // Write one register: hold cfg_we for exactly one rising edge.
    task automatic write_cal(input logic [2:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bsc_pkg::CFG_SENS:        cal_words.sens = value;
            bsc_pkg::CFG_OFFSET:      cal_words.offset = value;
            bsc_pkg::CFG_SENS_TEMP:   cal_words.sens_temp = value;
            bsc_pkg::CFG_OFFSET_TEMP: cal_words.offset_temp = value;
            bsc_pkg::CFG_REF_TEMP:    cal_words.ref_temp = value;
            bsc_pkg::CFG_TEMP_SLOPE:  cal_words.temp_slope = value;
            default: ;
        endcase
    endtask

    task automatic load_cal(input logic [15:0] w1, input logic [15:0] w2,
                            input logic [15:0] w3, input logic [15:0] w4,
                            input logic [15:0] w5, input logic [15:0] w6);
        write_cal(bsc_pkg::CFG_SENS, w1);
        write_cal(bsc_pkg::CFG_OFFSET, w2);
        write_cal(bsc_pkg::CFG_SENS_TEMP, w3);
        write_cal(bsc_pkg::CFG_OFFSET_TEMP, w4);
        write_cal(bsc_pkg::CFG_REF_TEMP, w5);
        write_cal(bsc_pkg::CFG_TEMP_SLOPE, w6);
        cal_sets++;
        @(negedge clk);
    endtask

    // Wait until every queued request was taken and every reading came back.
    task automatic drain();
        do
            @(negedge clk);
        while (items_taken != items_queued || pending_readings.size() != 0);
    endtask

    function automatic logic [15:0] jitter(input int base);
        return 16'(base + $urandom_range(0, 8000) - 4000);
    endfunction

    task automatic random_phase(input cal_style_t style);
        if (style == CAL_NEAR_TYPICAL)
            load_cal(jitter(46372), jitter(43981), jitter(29059),
                     jitter(27842), jitter(31553), jitter(28165));
        else
            load_cal(16'($urandom()), 16'($urandom()), 16'($urandom()),
                     16'($urandom()), 16'($urandom()), 16'($urandom()));
        repeat (RAND_PER_PHASE)
        begin
            conversion_t c;
            c = draw_conversion();
            queue_conversion(c.d1, c.d2);
        end
        drain();
    endtask

    // Driver: offer the backlog on raw_ch. A request stays on the bus until
    // taken; predict its reading at the edge where it is accepted.
    always @(posedge clk)
    begin : feed
        conversion_t next_conv;
        bit cold;
        if (!rst_n)
            raw_if.valid <= 1'b0;
        else
        begin
            if (raw_if.valid && raw_if.ready)
            begin
                pending_readings.push_back(
                    compensate(raw_if.raw_pressure, raw_if.raw_temperature, cold));
                items_taken++;
                if (cold)
                    cold_count++;
            end
            if (!raw_if.valid || raw_if.ready)
            begin
                if (raw_backlog.size() != 0
                    && (sender_steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_conv = raw_backlog.pop_front();
                    raw_if.valid <= 1'b1;
                    raw_if.raw_pressure <= next_conv.d1;
                    raw_if.raw_temperature <= next_conv.d2;
                end
                else
                    raw_if.valid <= 1'b0;
            end
        end
    end

    // Sink ready: random idling, or a long hold-off when one is asked for.
    always @(posedge clk)
    begin : sink
        if (!rst_n)
        begin
            comp_if.ready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_left != 0)
        begin
            comp_if.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_given != hold_asked)
        begin
            hold_given = hold_asked;
            hold_left = HOLD_LEN - 1;
            comp_if.ready <= 1'b0;
        end
        else
            comp_if.ready <= sink_steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: compare each delivered reading with the oldest prediction.
    always @(posedge clk)
    begin : watch
        reading_t want;
        if (rst_n && comp_if.valid && comp_if.ready)
        begin
            readings_seen++;
            if (pending_readings.size() == 0)
                flag_mismatch($sformatf("reading p=%0d t=%0d with no request pending",
                                        comp_if.pressure_pa, comp_if.temperature_centi));
            else
            begin
                want = pending_readings.pop_front();
                if (want.clipped)
                    clip_count++;
                if (comp_if.pressure_pa !== want.pressure)
                    flag_mismatch($sformatf("pressure_pa %0d, predicted %0d",
                                            comp_if.pressure_pa, want.pressure));
                if (comp_if.temperature_centi !== want.centi)
                    flag_mismatch($sformatf("temperature_centi %0d, predicted %0d",
                                            comp_if.temperature_centi, want.centi));
                if (comp_if.clipped !== want.clipped)
                    flag_mismatch($sformatf("clipped %0b, predicted %0b",
                                            comp_if.clipped, want.clipped));
            end
        end
    end

    // Watchdog: end the run with an error once cycle_count reaches CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        // Drive the configuration port and reset to known values from time zero.
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cal_words = '0;
        sender_steady = 1'b0;
        sink_steady = 1'b0;
        hold_asked = 0;

        // Hold reset, then release it away from the rising edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // All calibration words zero after reset: every reading is defined.
        cal_sets++;
        queue_conversion(24'h000000, 24'h000000);
        queue_conversion(24'hFFFFFF, 24'hFFFFFF);
        queue_conversion(24'h800000, 24'h7FFFFF);
        drain();

        // Typical calibration. Spare indexes get junk that must not land anywhere.
        write_cal(IDX_SPARE_LO, 16'hDEAD);
        write_cal(IDX_SPARE_HI, 16'hBEEF);
        load_cal(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
        write_cal(IDX_SPARE_LO, 16'hFFFF);
        write_cal(IDX_SPARE_HI, 16'h0000);
        @(negedge clk);
        queue_conversion(24'd6465444, 24'd8077636);   // room temperature
        queue_conversion(24'd6465444, 24'd8077568);   // exactly at the pivot
        queue_conversion(24'd6465444, 24'd8077567);   // just below the pivot
        queue_conversion(24'd6465444, 24'd7000000);   // cold
        queue_conversion(24'd6465444, 24'd0);         // very cold, extra term
        queue_conversion(24'd6465444, 24'hFFFFFF);    // hot
        queue_conversion(24'd0, 24'd8077636);
        queue_conversion(24'hFFFFFF, 24'd8077636);
        queue_conversion(24'hFFFFFF, 24'd0);
        queue_conversion(24'd0, 24'hFFFFFF);
        queue_conversion(24'hAAAAAA, 24'h555555);
        queue_conversion(24'h555555, 24'hAAAAAA);
        drain();

        // Every calibration word at its maximum.
        load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_conversion(24'h000000, 24'h000000);
        queue_conversion(24'hFFFFFF, 24'hFFFFFF);
        queue_conversion(24'hFFFFFF, 24'h000000);
        queue_conversion(24'h000000, 24'hFFFFFF);
        queue_conversion(24'h800000, 24'hFFFF00);
        drain();

        // Alternating extremes: zero reference, steep slope.
        load_cal(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        queue_conversion(24'hFFFFFF, 24'h000000);
        queue_conversion(24'hFFFFFF, 24'h000100);
        queue_conversion(24'h000001, 24'hFFFFFF);
        drain();

        // Random part. First a stretch where neither side ever idles.
        sender_steady = 1'b1;
        sink_steady = 1'b1;
        random_phase(CAL_NEAR_TYPICAL);
        sink_steady = 1'b0;

        // Back-pressure: the sink holds off while the sender keeps offering,
        // so the pipeline fills and raw_ch.ready drops.
        hold_asked++;
        random_phase(CAL_NEAR_TYPICAL);
        sender_steady = 1'b0;

        for (int ph = 2; ph < RAND_PHASES; ph++)
            random_phase(ph % 2 == 0 ? CAL_ANY : CAL_NEAR_TYPICAL);

        // Let stray results surface, then check nothing is left over.
        repeat (4 * PIPE_DEPTH) @(posedge clk);
        while (pending_readings.size() != 0)
        begin
            void'(pending_readings.pop_front());
            flag_mismatch("predicted reading never delivered");
        end

        $display("tb: %0d requests over %0d calibration sets, %0d readings delivered",
                 items_taken, cal_sets, readings_seen);
        $display("tb: %0d in the cold correction range, %0d saturated",
                 cold_count, clip_count);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
